// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fsqrt_pkg.sv
// ----------------------------------------------------------------------------
// fsqrt_pkg
// Types, constants and binary32 helper functions for the approximate sqrt.
// ----------------------------------------------------------------------------
package fsqrt_pkg;

    localparam logic [31:0] QNAN       = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
    localparam logic [31:0] GUESS_BIAS = 32'h2000_0000;
    localparam logic [31:0] GUESS_ADJ  = 32'h0040_0000;
    localparam logic signed [9:0] EXP_MIN  = -10'sd126;
    localparam logic signed [9:0] EXP_BIAS = 10'sd127;
    localparam logic signed [9:0] EXP_SAT  = 10'sd255;

    typedef struct packed {
        logic              sgn;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [9:0] exp;
        logic [23:0]       man;
    } fp_unp_t;

    // One divider iteration stage.
    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic signed [9:0] exp;
        logic [23:0]       mg;
        logic [25:0]       rem;
        logic [24:0]       q;
    } div_st_t;

    // Adder: after operand swap.
    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic              sub;
        logic signed [9:0] exp;
        logic [9:0]        dif;
        logic [23:0]       mx;
        logic [23:0]       my;
    } add_a_t;

    // Adder: after align and add.
    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic              sub;
        logic signed [9:0] exp;
        logic [27:0]       sum;
    } add_b_t;

    // Adder: normalized, ready to round.
    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic signed [9:0] exp;
        logic [24:0]       man;
        logic              st;
    } add_c_t;

    function automatic fp_unp_t fp_unpack(input logic [31:0] x);
        fp_unp_t u;
        u.sgn  = x[31];
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        u.zero = (x[30:0] == 31'd0);
        if (x[30:23] == 8'd0) begin
            u.exp = EXP_MIN;
            u.man = {1'b0, x[22:0]};
        end else begin
            u.exp = $signed({2'b00, x[30:23]}) - EXP_BIAS;
            u.man = {1'b1, x[22:0]};
        end
        return u;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else      n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // Round to nearest even; m is 1.23 plus a guard bit, value m * 2^e.
    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [9:0] e,
                                               input logic [24:0] m, input logic st);
        logic signed [9:0] eb;
        logic [9:0]        d;
        logic [4:0]        dc;
        logic [50:0]       ext;
        logic [24:0]       ms;
        logic              s;
        logic [7:0]        be;
        logic              inc;
        logic [30:0]       pk;
        eb = e + EXP_BIAS;
        if (eb >= EXP_SAT) return {sgn, INF_MAG};
        if (eb >= 10'sd1) begin
            ms  = m;
            s   = st;
            be  = m[24] ? eb[7:0] : 8'd0;
            ext = '0;
            d   = '0;
            dc  = '0;
        end else begin
            d   = 10'(10'sd1 - eb);
            dc  = (d > 10'd26) ? 5'd26 : d[4:0];
            ext = {m, 26'd0} >> dc;
            ms  = ext[50:26];
            s   = st | (|ext[25:0]);
            be  = 8'd0;
        end
        inc = ms[0] & (ms[1] | s);
        pk  = {be, ms[23:1]} + {30'd0, inc};
        return {sgn, pk};
    endfunction

    function automatic add_a_t add_prep(input logic [31:0] x, input logic [31:0] y);
        add_a_t  r;
        fp_unp_t ux;
        fp_unp_t uy;
        fp_unp_t big;
        fp_unp_t sml;
        ux = fp_unpack(x);
        uy = fp_unpack(y);
        r  = '0;
        if (ux.nan || uy.nan || (ux.inf && uy.inf && (ux.sgn != uy.sgn))) begin
            r.spec = 1'b1;
            r.sval = QNAN;
        end else if (ux.inf) begin
            r.spec = 1'b1;
            r.sval = x;
        end else if (uy.inf) begin
            r.spec = 1'b1;
            r.sval = y;
        end
        if (x[30:0] >= y[30:0]) begin
            big = ux;
            sml = uy;
        end else begin
            big = uy;
            sml = ux;
        end
        r.sgn = big.sgn;
        r.sub = ux.sgn ^ uy.sgn;
        r.exp = big.exp;
        r.dif = 10'(big.exp - sml.exp);
        r.mx  = big.man;
        r.my  = sml.man;
        return r;
    endfunction

    function automatic add_b_t add_align(input add_a_t a);
        add_b_t      r;
        logic [4:0]  dd;
        logic [53:0] sh;
        logic [26:0] al;
        dd = (a.dif > 10'd27) ? 5'd27 : a.dif[4:0];
        sh = {a.my, 3'b000, 27'd0} >> dd;
        al = sh[53:27];
        al[0] = al[0] | (|sh[26:0]);
        r.spec = a.spec;
        r.sval = a.sval;
        r.sgn  = a.sgn;
        r.sub  = a.sub;
        r.exp  = a.exp;
        if (a.sub) r.sum = {1'b0, a.mx, 3'b000} - {1'b0, al};
        else       r.sum = {1'b0, a.mx, 3'b000} + {1'b0, al};
        return r;
    endfunction

    function automatic add_c_t add_norm(input add_b_t b);
        add_c_t            r;
        logic [26:0]       n;
        logic [4:0]        lz;
        logic signed [9:0] room;
        logic [4:0]        sh;
        r.spec = b.spec;
        r.sval = b.sval;
        r.sgn  = b.sgn;
        r.exp  = b.exp;
        lz   = lzc27(b.sum[26:0]);
        room = b.exp - EXP_MIN;
        sh   = '0;
        if (b.sum[27]) begin
            n     = b.sum[27:1];
            n[0]  = n[0] | b.sum[0];
            r.exp = b.exp + 10'sd1;
        end else begin
            sh    = (room < $signed({5'd0, lz})) ? room[4:0] : lz;
            n     = b.sum[26:0] << sh;
            r.exp = b.exp - $signed({5'd0, sh});
        end
        if (!b.spec && (b.sum == 28'd0)) begin
            // exact cancellation gives +0; like-signed zeros keep their sign
            r.spec = 1'b1;
            r.sval = {b.sub ? 1'b0 : b.sgn, 31'd0};
        end
        r.man = n[26:2];
        r.st  = n[1] | n[0];
        return r;
    endfunction

    function automatic logic [31:0] add_round(input add_c_t c);
        return c.spec ? c.sval : round_pack(c.sgn, c.exp, c.man, c.st);
    endfunction

    // 0.25 * y, rounded (only subnormal results lose bits).
    function automatic logic [31:0] quarter(input logic [31:0] y);
        fp_unp_t u;
        u = fp_unpack(y);
        if (u.nan)               return QNAN;
        if (u.inf || u.zero)     return y;
        return round_pack(u.sgn, u.exp - 10'sd2, {u.man, 1'b0}, 1'b0);
    endfunction

endpackage

// File: rtl/core/fsqrt_div.sv
// ----------------------------------------------------------------------------
// fsqrt_div
// Pipelined binary32 divider, one quotient bit per stage, RNE, subnormals.
// ----------------------------------------------------------------------------
module fsqrt_div #(
    parameter int SIDE_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       num,
    input  logic [31:0]       den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       quo,
    output logic [SIDE_W-1:0] out_side
);
    import fsqrt_pkg::*;

    localparam int NIT = 25;

    // unpack / normalize stage
    logic              p_vld_reg;
    logic              p_spec_reg, p_spec_next;
    logic [31:0]       p_sval_reg, p_sval_next;
    logic              p_sgn_reg,  p_sgn_next;
    logic signed [9:0] p_exp_reg,  p_exp_next;
    logic [23:0]       p_ma_reg,   p_ma_next;
    logic [23:0]       p_mg_reg,   p_mg_next;
    logic [SIDE_W-1:0] p_side_reg;

    fp_unp_t    un, ud;
    logic [4:0] lza, lzd;

    always_comb begin
        un = fp_unpack(num);
        ud = fp_unpack(den);
        lza = lzc27({un.man, 3'b111});
        lzd = lzc27({ud.man, 3'b111});
        p_sgn_next  = un.sgn ^ ud.sgn;
        p_ma_next   = un.man << lza;
        p_mg_next   = ud.man << lzd;
        p_exp_next  = (un.exp - $signed({5'd0, lza})) - (ud.exp - $signed({5'd0, lzd}));
        p_spec_next = 1'b1;
        if (un.nan || ud.nan || (un.zero && ud.zero) || (un.inf && ud.inf))
            p_sval_next = QNAN;
        else if (un.inf || ud.zero)
            p_sval_next = {p_sgn_next, INF_MAG};
        else if (un.zero || ud.inf)
            p_sval_next = {p_sgn_next, 31'd0};
        else begin
            p_sval_next = '0;
            p_spec_next = 1'b0;
        end
    end

    // iteration stages; index 0 is the setup stage
    div_st_t           st_reg   [0:NIT];
    div_st_t           st_next  [0:NIT];
    logic              vld_reg  [0:NIT];
    logic [SIDE_W-1:0] side_reg [0:NIT];

    always_comb begin
        st_next[0]      = '0;
        st_next[0].spec = p_spec_reg;
        st_next[0].sval = p_sval_reg;
        st_next[0].sgn  = p_sgn_reg;
        st_next[0].mg   = p_mg_reg;
        if (p_ma_reg < p_mg_reg) begin
            st_next[0].rem = {1'b0, p_ma_reg, 1'b0};
            st_next[0].exp = p_exp_reg - 10'sd1;
        end else begin
            st_next[0].rem = {2'b00, p_ma_reg};
            st_next[0].exp = p_exp_reg;
        end
    end

    for (genvar k = 0; k < NIT; k++) begin : g_iter
        logic        ge;
        logic [25:0] diff;
        always_comb begin
            ge   = st_reg[k].rem >= {2'b00, st_reg[k].mg};
            diff = ge ? (st_reg[k].rem - {2'b00, st_reg[k].mg}) : st_reg[k].rem;
            st_next[k+1]     = st_reg[k];
            st_next[k+1].rem = {diff[24:0], 1'b0};
            st_next[k+1].q   = {st_reg[k].q[23:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            for (int i = 0; i <= NIT; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            p_vld_reg  <= in_valid;
            vld_reg[0] <= p_vld_reg;
            for (int i = 1; i <= NIT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_spec_reg  <= p_spec_next;
            p_sval_reg  <= p_sval_next;
            p_sgn_reg   <= p_sgn_next;
            p_exp_reg   <= p_exp_next;
            p_ma_reg    <= p_ma_next;
            p_mg_reg    <= p_mg_next;
            p_side_reg  <= in_side;
            side_reg[0] <= p_side_reg;
            for (int i = 0; i <= NIT; i++) st_reg[i] <= st_next[i];
            for (int i = 1; i <= NIT; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    // rounding stage
    logic              o_vld_reg;
    logic [31:0]       o_quo_reg, o_quo_next;
    logic [SIDE_W-1:0] o_side_reg;

    always_comb begin
        o_quo_next = st_reg[NIT].spec ? st_reg[NIT].sval :
            round_pack(st_reg[NIT].sgn, st_reg[NIT].exp, st_reg[NIT].q,
                       st_reg[NIT].rem != 26'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) o_vld_reg <= 1'b0;
        else if (en)  o_vld_reg <= vld_reg[NIT];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_quo_reg  <= o_quo_next;
            o_side_reg <= side_reg[NIT];
        end
    end

    assign out_valid = o_vld_reg;
    assign quo       = o_quo_reg;
    assign out_side  = o_side_reg;

endmodule

// File: rtl/core/float_sqrt_bit_guess_newton_unit.sv
// Throughput: one word per cycle while the output is not stalled; the divider
//   pipelines (25 iteration stages, one quotient bit per stage) and the 4-stage
//   adders set the depth, not the rate.
// Backpressure freezes the whole pipeline; s_ready = !m_valid || m_ready.
// Reset (aresetn, synchronous, active low) clears all valid bits; data
//   registers are not reset.
// ----------------------------------------------------------------------------
// float_sqrt_bit_guess_newton_unit
// Approximate binary32 sqrt: bit-pattern guess then two simplified Newton
// steps, y1 = g + a/g and r = 0.25*y1 + a/y1, all in RNE single precision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module float_sqrt_bit_guess_newton_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_root_bits
);
    import fsqrt_pkg::*;

    // Single global advance: every stage moves when the output slot is free
    // or being drained this cycle.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- guess stage ----------------
    // g = 0x20000000 + (v >>> 1) - 0x400000, modulo 2^32
    logic        in_vld_reg;
    logic [31:0] a_reg, a_next;
    logic [31:0] g_reg, g_next;

    assign a_next = s_value_bits;
    assign g_next = GUESS_BIAS + {s_value_bits[31], s_value_bits[31:1]} - GUESS_ADJ;

    // ---------------- q1 = a / g ----------------
    logic        d1_vld;
    logic [31:0] q1;
    logic [63:0] d1_side;   // {a, g}

    fsqrt_div #(.SIDE_W(64)) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (in_vld_reg),
        .num       (a_reg),
        .den       (g_reg),
        .in_side   ({a_reg, g_reg}),
        .out_valid (d1_vld),
        .quo       (q1),
        .out_side  (d1_side)
    );

    // ---------------- y1 = g + q1 (4 stages) ----------------
    logic        ya_vld_reg, yb_vld_reg, yc_vld_reg, y1_vld_reg;
    add_a_t      ya_reg, ya_next;
    add_b_t      yb_reg, yb_next;
    add_c_t      yc_reg, yc_next;
    logic [31:0] y1_reg, y1_next;
    logic [31:0] ya_a_reg, yb_a_reg, yc_a_reg, y1_a_reg;   // operand a rides along

    assign ya_next = add_prep(d1_side[31:0], q1);
    assign yb_next = add_align(ya_reg);
    assign yc_next = add_norm(yb_reg);
    assign y1_next = add_round(yc_reg);

    // ---------------- q2 = a / y1 ----------------
    logic        d2_vld;
    logic [31:0] q2;
    logic [31:0] d2_y1;

    fsqrt_div #(.SIDE_W(32)) u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (y1_vld_reg),
        .num       (y1_a_reg),
        .den       (y1_reg),
        .in_side   (y1_reg),
        .out_valid (d2_vld),
        .quo       (q2),
        .out_side  (d2_y1)
    );

    // ---------------- prod = 0.25 * y1 ----------------
    logic        p_vld_reg;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] q2_reg;

    assign prod_next = quarter(d2_y1);

    // ---------------- r = prod + q2 (4 stages) ----------------
    logic        ra_vld_reg, rb_vld_reg, rc_vld_reg, out_vld_reg;
    add_a_t      ra_reg, ra_next;
    add_b_t      rb_reg, rb_next;
    add_c_t      rc_reg, rc_next;
    logic [31:0] out_reg, out_next;

    assign ra_next  = add_prep(prod_reg, q2_reg);
    assign rb_next  = add_align(ra_reg);
    assign rc_next  = add_norm(rb_reg);
    assign out_next = add_round(rc_reg);   // any NaN here is already 0x7FC00000

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            ya_vld_reg  <= 1'b0;
            yb_vld_reg  <= 1'b0;
            yc_vld_reg  <= 1'b0;
            y1_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            ra_vld_reg  <= 1'b0;
            rb_vld_reg  <= 1'b0;
            rc_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg  <= s_valid;
            ya_vld_reg  <= d1_vld;
            yb_vld_reg  <= ya_vld_reg;
            yc_vld_reg  <= yb_vld_reg;
            y1_vld_reg  <= yc_vld_reg;
            p_vld_reg   <= d2_vld;
            ra_vld_reg  <= p_vld_reg;
            rb_vld_reg  <= ra_vld_reg;
            rc_vld_reg  <= rb_vld_reg;
            out_vld_reg <= rc_vld_reg;
        end
    end

    // ---------------- data path ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg    <= a_next;
            g_reg    <= g_next;
            ya_reg   <= ya_next;
            ya_a_reg <= d1_side[63:32];
            yb_reg   <= yb_next;
            yb_a_reg <= ya_a_reg;
            yc_reg   <= yc_next;
            yc_a_reg <= yb_a_reg;
            y1_reg   <= y1_next;
            y1_a_reg <= yc_a_reg;
            prod_reg <= prod_next;
            q2_reg   <= q2;
            ra_reg   <= ra_next;
            rb_reg   <= rb_next;
            rc_reg   <= rc_next;
            out_reg  <= out_next;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_root_bits = out_reg;

    // ---------------- assertions ----------------
    logic m_is_nan;
    assign m_is_nan = (m_root_bits[30:23] == 8'hFF) && (m_root_bits[22:0] != 23'd0);

    `ASSERT_CLK(a_nan_canon, !(m_valid && m_is_nan) || (m_root_bits == QNAN), "NaN not canonical")
    `ASSERT_NEXT(a_stall_freeze, !s_ready, $stable({p_vld_reg, q2_reg, rc_vld_reg}), "stall moved")
    `ASSERT_NEXT(a_entry, s_valid && s_ready, in_vld_reg, "accepted word did not enter the pipeline")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the approximate binary32 sqrt unit. A bit-exact
// software predictor (guess, two Newton steps, RNE single rounding) sets the
// expected root for every accepted word; a checker compares results in order
// while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [31:0] CANON_QNAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
    localparam logic [31:0] SEED_BIAS  = 32'h2000_0000;
    localparam logic [31:0] SEED_ADJ   = 32'h0040_0000;
    localparam int          PIPE_DEPTH = 66;
    localparam int          CYCLE_CAP  = 300000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_value_bits;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_root_bits;

    logic [31:0] root_fifo[$];   // expected roots, oldest first
    int          error_count;
    int          cycle_count;
    int          send_gap_pct;   // chance (percent) the sender idles in a cycle
    int          sink_stall_pct; // chance (percent) m_ready is low in a cycle
    int          hold_request;   // long sink hold-off, picked up by the sink
    int          hold_left;

    float_sqrt_bit_guess_newton_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value_bits (s_value_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_root_bits  (m_root_bits)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor
    // binary32 pattern -> real, exact (subnormals normalized, inf/NaN kept)
    function automatic real f32_to_real(input logic [31:0] b);
        logic [23:0] mant;
        logic [63:0] dbl;
        int          ex;
        ex   = b[30:23];
        mant = {1'b0, b[22:0]};
        if (ex == 255) begin
            dbl = {b[31], 11'h7FF, b[22:0], 29'd0};
        end else if (b[30:0] == 31'd0) begin
            dbl = {b[31], 63'd0};
        end else begin
            if (ex == 0) begin
                ex = 1;
                while (!mant[23]) begin
                    mant = mant << 1;
                    ex--;
                end
            end else begin
                mant[23] = 1'b1;
            end
            dbl = {b[31], 11'(ex + 896), mant[22:0], 29'd0};
        end
        return $bitstoreal(dbl);
    endfunction

    // real -> binary32, round to nearest even, subnormals kept. Double
    // rounding through binary64 is harmless for one +, *, / of binary32 inputs.
    function automatic logic [31:0] real_to_f32(input real r);
        logic [63:0] dbl;
        logic [63:0] mant;
        logic [63:0] kept;
        logic [63:0] rest;
        logic [63:0] halfway;
        logic [31:0] packed_mag;
        int          dexp;
        int          bexp;
        int          shamt;
        dbl  = $realtobits(r);
        dexp = dbl[62:52];
        if (dexp == 2047)
            return (dbl[51:0] != 52'd0) ? CANON_QNAN : {dbl[63], INF_MAG};
        if (dexp == 0)
            return {dbl[63], 31'd0};
        bexp = dexp - 1023 + 127;
        if (bexp >= 255)
            return {dbl[63], INF_MAG};
        mant    = {11'd0, 1'b1, dbl[51:0]};
        shamt   = (bexp >= 1) ? 29 : 30 - bexp;
        if (shamt > 63) shamt = 63;
        kept    = mant >> shamt;
        rest    = mant & ((64'd1 << shamt) - 64'd1);
        halfway = 64'd1 << (shamt - 1);
        if (rest > halfway || (rest == halfway && kept[0]))
            kept = kept + 64'd1;
        // hidden bit carries into the exponent field; overflow lands on inf
        if (bexp >= 1) packed_mag = 32'((bexp - 1) << 23) + kept[31:0];
        else           packed_mag = kept[31:0];
        return {dbl[63], packed_mag[30:0]};
    endfunction

    function automatic logic is_nan32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // single division; a zero divisor is resolved by hand
    function automatic logic [31:0] fdiv32(input logic [31:0] n, input logic [31:0] d);
        if (d[30:0] == 31'd0) begin
            if (is_nan32(n) || n[30:0] == 31'd0) return CANON_QNAN;
            return {n[31] ^ d[31], INF_MAG};
        end
        return real_to_f32(f32_to_real(n) / f32_to_real(d));
    endfunction

    function automatic logic [31:0] fadd32(input logic [31:0] x, input logic [31:0] y);
        return real_to_f32(f32_to_real(x) + f32_to_real(y));
    endfunction

    function automatic logic [31:0] approx_root(input logic [31:0] v);
        logic [31:0] shifted;
        logic [31:0] seed;
        logic [31:0] step1;
        logic [31:0] quarter_y;
        logic [31:0] root;
        shifted   = (v >> 1) | (v & 32'h8000_0000);
        seed      = SEED_BIAS + shifted - SEED_ADJ;
        step1     = fadd32(seed, fdiv32(v, seed));
        quarter_y = real_to_f32(f32_to_real(step1) * 0.25);
        root      = fadd32(quarter_y, fdiv32(v, step1));
        return is_nan32(root) ? CANON_QNAN : root;
    endfunction

    // ---------------------------------------------------------------- sink side
    // m_ready: random stalls, or a counted long hold-off on request
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result checker: every accepted word against the oldest expectation
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (root_fifo.size() == 0) begin
                $error("root_bits: no result expected, got %h", m_root_bits);
                error_count++;
            end else begin
                want = root_fifo.pop_front();
                if (m_root_bits !== want) begin
                    $error("root_bits: expected %h, got %h", want, m_root_bits);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("float_sqrt_bit_guess_newton_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sender
    // offer one word, hold it until taken, then maybe idle for a while
    task automatic send_word(input logic [31:0] v);
        s_valid      <= 1'b1;
        s_value_bits <= v;
        do @(posedge aclk); while (!s_ready);
        root_fifo.push_back(approx_root(v));
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // well-formed positive operands most of the time, raw noise otherwise
    function automatic logic [31:0] random_operand();
        logic [7:0] ex;
        if ($urandom_range(99) < 60) begin
            ex = 8'($urandom_range(1, 254));
            return {1'b0, ex, 23'($urandom())};
        end
        return $urandom();
    endfunction

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (root_fifo.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        logic [31:0] corner[$];
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        corner = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h4080_0000,
                   32'h3E80_0000, 32'h4049_0FDB, 32'h7F7F_FFFF, 32'h0000_0001,
                   32'h007F_FFFF, 32'h0080_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'hBF80_0000,
                   32'hC080_0000,   // seed is +0, dividend nonzero
                   32'h8000_0001, 32'hFF7F_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corner[i]) send_word(corner[i]);
        wait_drain();
    endtask

    task automatic test_random(input int gap_pct, input int stall_pct, input int count);
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_word(random_operand());
        wait_drain();
    endtask

    // sink holds off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 250;
        repeat (120) send_word(random_operand());
        wait_drain();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_value_bits   = '0;
        m_ready        = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(0, 0, 80);
        test_random(49, 0, 80);
        test_random(0, 49, 80);
        test_random(18, 18, 80);
        test_backpressure();

        if (error_count == 0)
            $display("float_sqrt_bit_guess_newton_unit verification clean");
        else
            $display("float_sqrt_bit_guess_newton_unit verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fsqrt_pkg.sv
rtl/core/fsqrt_div.sv
rtl/core/float_sqrt_bit_guess_newton_unit.sv
verif/testbench.sv
